### design/pms_pkg.sv
// Shared constants for the parking maneuver sequencer: opcodes, phases, commands, registers.
package pms_pkg;

  // Opcode carried on in_tuser
  localparam logic [1:0] OP_UPDATE  = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_STOP    = 2'd2;

  // Sequence phases
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_EXEC   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Maneuver steps inside the execute phase
  localparam logic STEP_TO_EDGE = 1'b0;
  localparam logic STEP_TURN    = 1'b1;

  // Steering and speed command codes
  localparam int unsigned CMD_W = 7;
  localparam logic [CMD_W-1:0] CMD_NEUTRAL   = 7'd50;
  localparam logic [CMD_W-1:0] CMD_RIGHT     = 7'd64;
  localparam logic [CMD_W-1:0] CMD_STOP      = 7'd50;
  localparam logic [CMD_W-1:0] CMD_FORWARD   = 7'd70;
  localparam logic [CMD_W-1:0] CMD_REVERSE   = 7'd35;
  localparam logic [CMD_W-1:0] CMD_REV_SLOW  = 7'd45;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_MARGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_STOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT  = 3'd4;

  // Register reset values
  localparam logic [15:0] WALL_MARGIN_RST = 16'd100;
  localparam logic [31:0] MIN_GAP_RST     = 32'd300000;
  localparam logic [15:0] REAR_STOP_RST   = 16'd100;
  localparam logic [7:0]  TURN_TICKS_RST  = 8'd30;
  localparam logic [31:0] STALE_LIMIT_RST = 32'd100000;

  // Field widths
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned OUT_W   = 24;

endpackage

### design/parking_maneuver_sequencer_unit.sv
// Parking maneuver sequencer: stream in control updates, stream out drive commands.
//
//  channel  | direction | payload                                     | handshake
//  ---------+-----------+---------------------------------------------+----------------------
//  in_      | slave     | tuser opcode, tdata sensors/stamps/time/ack  | in_tvalid/in_tready
//  out_     | master    | tdata steer/speed/status flags               | out_tvalid/out_tready
//  cfg_     | slave     | cfg_index register number, cfg_data value    | cfg_valid/cfg_ready
//
// One transaction per cycle sustained unless out_tready stalls. Path: an input register,
// then one pass of compares and 48-bit subtracts into the result register.
// rst_n is synchronous, active low; it clears sequence state and loads the
// register defaults. A stalled output register holds the input stage, which
// still takes a transaction when the result stage frees in that same cycle.
// cfg_ready is always high.
module parking_maneuver_sequencer_unit
  import pms_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48,
  // in_tdata: four time fields, two distances and the ack, rounded up to bytes
  localparam int unsigned IN_BITS = 4 * TIME_BITS + 2 * DIST_W + 1,
  localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata, low bit up: now_us, left_mm, left_stamp_us, right_stamp_us, rear_mm,
  // rear_stamp_us, done_ack, zero fill
  input  logic [IN_W-1:0]       in_tdata,
  // tuser: opcode
  input  logic [1:0]            in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata, low bit up: steer_cmd, speed_cmd, updated, parking_done, active,
  // rear_warn, zero fill
  output logic [OUT_W-1:0]      out_tdata,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int unsigned TB       = TIME_BITS;
  // field offsets inside in_tdata
  localparam int unsigned O_NOW    = 0;
  localparam int unsigned O_LEFT   = O_NOW + TB;
  localparam int unsigned O_LST    = O_LEFT + DIST_W;
  localparam int unsigned O_RST    = O_LST + TB;
  localparam int unsigned O_REAR   = O_RST + TB;
  localparam int unsigned O_BST    = O_REAR + DIST_W;
  localparam int unsigned O_ACK    = O_BST + TB;

  // configuration registers
  logic [DIST_W-1:0] wall_margin_r;
  logic [CFG_W-1:0]  min_gap_r;
  logic [DIST_W-1:0] rear_stop_r;
  logic [TICK_W-1:0] turn_ticks_r;
  logic [CFG_W-1:0]  stale_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_margin_r <= WALL_MARGIN_RST;
      min_gap_r     <= MIN_GAP_RST;
      rear_stop_r   <= REAR_STOP_RST;
      turn_ticks_r  <= TURN_TICKS_RST;
      stale_limit_r <= STALE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WALL_MARGIN: wall_margin_r <= cfg_data[DIST_W-1:0];
        REG_MIN_GAP:     min_gap_r     <= cfg_data;
        REG_REAR_STOP:   rear_stop_r   <= cfg_data[DIST_W-1:0];
        REG_TURN_TICKS:  turn_ticks_r  <= cfg_data[TICK_W-1:0];
        REG_STALE_LIMIT: stale_limit_r <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic            s1_valid_r;
  logic [IN_W-1:0] s1_data_r;
  logic [1:0]      s1_op_r;
  logic            out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic            advance;

  // stage 1 moves into the result register when that register is empty or leaving
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_op_r   <= in_tuser;
    end
  end

  // ---------------- field unpack ----------------
  logic [TB-1:0]     now_us, lst_us, rst_us, bst_us;
  logic [DIST_W-1:0] left_mm, rear_mm;
  logic              done_ack;

  assign now_us   = s1_data_r[O_NOW +: TB];
  assign left_mm  = s1_data_r[O_LEFT +: DIST_W];
  assign lst_us   = s1_data_r[O_LST +: TB];
  assign rst_us   = s1_data_r[O_RST +: TB];
  assign rear_mm  = s1_data_r[O_REAR +: DIST_W];
  assign bst_us   = s1_data_r[O_BST +: TB];
  assign done_ack = s1_data_r[O_ACK];

  // ---------------- sequence state ----------------
  logic [1:0]        phase_r, phase_nxt;
  logic              step_r, step_nxt;
  logic              gap_open_r, gap_open_nxt;
  logic [DIST_W-1:0] wall_min_r, wall_min_nxt;
  logic              wall_min_valid_r, wall_min_valid_nxt;
  logic [TB-1:0]     gap_start_r, gap_start_nxt;
  logic [TB-1:0]     gap_len_r, gap_len_nxt;
  logic [TICK_W-1:0] turn_count_r, turn_count_nxt;
  logic [CMD_W-1:0]  steer_r, steer_nxt;
  logic [CMD_W-1:0]  speed_r, speed_nxt;
  logic              done_r, done_nxt;
  logic              active_r, active_nxt;
  logic              updated, warn;

  // sensor freshness: wrapped age against the limit
  logic [TB-1:0] age_l, age_r, age_b;
  logic          fresh;
  assign age_l = now_us - lst_us;
  assign age_r = now_us - rst_us;
  assign age_b = now_us - bst_us;
  assign fresh = (age_l <= TB'(stale_limit_r)) && (age_r <= TB'(stale_limit_r)) &&
                 (age_b <= TB'(stale_limit_r));

  // wall tracking: first reading seeds the minimum and counts as wall
  logic [DIST_W-1:0] min_upd;
  logic [DIST_W:0]   wall_thr;
  logic              seen;
  assign min_upd  = !wall_min_valid_r ? left_mm :
                    (left_mm < wall_min_r) ? left_mm : wall_min_r;
  assign wall_thr = {1'b0, min_upd} + {1'b0, wall_margin_r};
  assign seen     = wall_min_valid_r && ({1'b0, left_mm} > wall_thr);

  logic [TICK_W-1:0] tc_step;
  logic [TB-1:0]     len_calc;

  always_comb begin
    phase_nxt          = phase_r;
    step_nxt           = step_r;
    gap_open_nxt       = gap_open_r;
    wall_min_nxt       = wall_min_r;
    wall_min_valid_nxt = wall_min_valid_r;
    gap_start_nxt      = gap_start_r;
    gap_len_nxt        = gap_len_r;
    turn_count_nxt     = turn_count_r;
    steer_nxt          = steer_r;
    speed_nxt          = speed_r;
    done_nxt           = done_r;
    active_nxt         = active_r;
    updated            = 1'b0;
    warn               = 1'b0;
    tc_step            = turn_count_r;
    len_calc           = (now_us < gap_start_r) ? '0 : now_us - gap_start_r;

    if (s1_op_r == OP_RESTART || s1_op_r == OP_STOP) begin
      phase_nxt          = PH_SEARCH;
      step_nxt           = STEP_TO_EDGE;
      gap_open_nxt       = 1'b0;
      wall_min_nxt       = '0;
      wall_min_valid_nxt = 1'b0;
      gap_start_nxt      = '0;
      gap_len_nxt        = '0;
      turn_count_nxt     = '0;
      steer_nxt          = CMD_NEUTRAL;
      speed_nxt          = CMD_STOP;
      done_nxt           = 1'b0;
      active_nxt         = (s1_op_r == OP_RESTART);
    end else if (s1_op_r == OP_UPDATE && fresh) begin
      updated = 1'b1;
      unique case (phase_r)
        PH_SEARCH: begin
          steer_nxt          = CMD_NEUTRAL;
          speed_nxt          = CMD_FORWARD;
          wall_min_nxt       = min_upd;
          wall_min_valid_nxt = 1'b1;
          if (seen != gap_open_r) begin
            if (!gap_open_r) begin
              gap_start_nxt = now_us;
              gap_open_nxt  = 1'b1;
            end else begin
              gap_len_nxt  = len_calc;
              gap_open_nxt = 1'b0;
            end
          end
          if (gap_len_nxt >= TB'(min_gap_r)) begin
            phase_nxt          = PH_EXEC;
            turn_count_nxt     = '0;
            step_nxt           = STEP_TO_EDGE;
            wall_min_valid_nxt = 1'b0;
          end
        end
        PH_EXEC: begin
          if (step_r == STEP_TO_EDGE) begin
            wall_min_nxt       = min_upd;
            wall_min_valid_nxt = 1'b1;
            gap_open_nxt       = seen;
            steer_nxt          = CMD_NEUTRAL;
            if (seen) begin
              speed_nxt = CMD_STOP;
              step_nxt  = STEP_TURN;
            end else begin
              speed_nxt = CMD_REVERSE;
            end
          end else begin
            if (turn_count_r < turn_ticks_r) begin
              steer_nxt = CMD_RIGHT;
              speed_nxt = CMD_REV_SLOW;
              tc_step   = turn_count_r + 1'b1;
            end else begin
              steer_nxt = CMD_NEUTRAL;
              speed_nxt = CMD_REVERSE;
              warn      = 1'b1;
            end
            turn_count_nxt = tc_step;
            if (tc_step >= turn_ticks_r && rear_mm <= rear_stop_r) begin
              steer_nxt = CMD_NEUTRAL;
              speed_nxt = CMD_STOP;
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_DONE: begin
          if (done_ack) begin
            active_nxt = 1'b0;
            done_nxt   = 1'b1;
            steer_nxt  = CMD_NEUTRAL;
            speed_nxt  = CMD_STOP;
          end
        end
        default: begin
          steer_nxt = CMD_NEUTRAL;
          speed_nxt = CMD_STOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SEARCH;
      step_r           <= STEP_TO_EDGE;
      gap_open_r       <= 1'b0;
      wall_min_r       <= '0;
      wall_min_valid_r <= 1'b0;
      gap_start_r      <= '0;
      gap_len_r        <= '0;
      turn_count_r     <= '0;
      steer_r          <= CMD_NEUTRAL;
      speed_r          <= CMD_STOP;
      done_r           <= 1'b0;
      active_r         <= 1'b0;
    end else if (advance) begin
      phase_r          <= phase_nxt;
      step_r           <= step_nxt;
      gap_open_r       <= gap_open_nxt;
      wall_min_r       <= wall_min_nxt;
      wall_min_valid_r <= wall_min_valid_nxt;
      gap_start_r      <= gap_start_nxt;
      gap_len_r        <= gap_len_nxt;
      turn_count_r     <= turn_count_nxt;
      steer_r          <= steer_nxt;
      speed_r          <= speed_nxt;
      done_r           <= done_nxt;
      active_r         <= active_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, warn, active_nxt, done_nxt, updated, speed_nxt, steer_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- checks ----------------
  // finishing clears assist mode, so both flags never show together
  a_done_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[15] && out_tdata[16]))
    else $error("parking_done and active both set");

  // rear warning only on a stepped update with the wheels straight
  a_warn_reverse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17]) |-> (out_tdata[14] && out_tdata[6:0] == CMD_NEUTRAL))
    else $error("rear_warn without straight update");

  // a stage-1 transaction that moves always shows up as a result
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("advanced transaction lost");

  // an empty result stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

### bench/parking_maneuver_sequencer_unit_test.sv
// Self-checking stream testbench for the parking maneuver sequencer unit.
module parking_maneuver_sequencer_unit_test;
  import pms_pkg::*;

  // Input tdata is 225 payload bits rounded up to whole bytes.
  localparam int unsigned SENSE_W = 232;
  // Opcode three has no meaning; the block must report state and step nothing.
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Long receiver hold-off, long enough to back the pipeline up into in_tready.
  localparam int unsigned HOLD_CYCLES = 300;
  // Quiet cycles after the last result before a register write or the verdict.
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned NOISE_PCT = 8;

  // One control update, first member in the top bits so now_us lands at bit 0.
  typedef struct packed {
    logic        ack;
    logic [47:0] rear_stamp;
    logic [15:0] rear;
    logic [47:0] right_stamp;
    logic [47:0] left_stamp;
    logic [15:0] left;
    logic [47:0] now;
  } sense_t;

  // One drive command transaction, steer_cmd at bit 0.
  typedef struct packed {
    logic             rear_warn;
    logic             active;
    logic             parking_done;
    logic             updated;
    logic [CMD_W-1:0] speed;
    logic [CMD_W-1:0] steer;
  } cmd_t;

  // Tracks the sequencer's registers and state and holds the drive commands
  // still owed by the block.
  class drive_cmd_tracker;
    logic [15:0]      wall_margin;
    logic [31:0]      min_gap;
    logic [15:0]      rear_stop;
    logic [7:0]       turn_ticks;
    logic [31:0]      stale_limit;

    logic [1:0]       phase;
    logic             step;
    logic             gap_open;
    logic [15:0]      wall_min;
    logic             wall_valid;
    logic [47:0]      gap_start;
    logic [47:0]      gap_len;
    logic [7:0]       turn_count;
    logic [CMD_W-1:0] steer;
    logic [CMD_W-1:0] speed;
    logic             done_f;
    logic             active_f;

    cmd_t             due_cmds[$];
    int               mismatches;
    int               results_seen;

    function new();
      wall_margin  = WALL_MARGIN_RST;
      min_gap      = MIN_GAP_RST;
      rear_stop    = REAR_STOP_RST;
      turn_ticks   = TURN_TICKS_RST;
      stale_limit  = STALE_LIMIT_RST;
      mismatches   = 0;
      results_seen = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      phase      = PH_SEARCH;
      step       = STEP_TO_EDGE;
      gap_open   = 1'b0;
      wall_min   = '0;
      wall_valid = 1'b0;
      gap_start  = '0;
      gap_len    = '0;
      turn_count = '0;
      steer      = CMD_NEUTRAL;
      speed      = CMD_STOP;
      done_f     = 1'b0;
      active_f   = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_WALL_MARGIN: wall_margin = val[15:0];
        REG_MIN_GAP:     min_gap     = val;
        REG_REAR_STOP:   rear_stop   = val[15:0];
        REG_TURN_TICKS:  turn_ticks  = val[7:0];
        REG_STALE_LIMIT: stale_limit = val;
        default: ;
      endcase
    endfunction

    // Age wraps modulo 2^48.
    function logic is_fresh(logic [47:0] now, logic [47:0] stamp);
      logic [47:0] age;
      age = now - stamp;
      return age <= {16'd0, stale_limit};
    endfunction

    // Open space when the reading clears the tracked wall minimum by the margin.
    function logic open_space(logic [15:0] reading);
      logic [16:0] lim;
      if (!wall_valid) begin
        wall_min   = reading;
        wall_valid = 1'b1;
        return 1'b0;
      end
      if (reading < wall_min) wall_min = reading;
      lim = {1'b0, wall_min} + {1'b0, wall_margin};
      return {1'b0, reading} > lim;
    endfunction

    function void take_update(logic [1:0] op, sense_t s);
      cmd_t c;
      logic upd;
      logic warn;
      logic seen;
      upd  = 1'b0;
      warn = 1'b0;
      if (op == OP_RESTART) begin
        clear_seq();
        active_f = 1'b1;
      end else if (op == OP_STOP) begin
        clear_seq();
      end else if (op == OP_UPDATE && is_fresh(s.now, s.left_stamp) &&
                   is_fresh(s.now, s.right_stamp) && is_fresh(s.now, s.rear_stamp)) begin
        upd = 1'b1;
        case (phase)
          PH_SEARCH: begin
            steer = CMD_NEUTRAL;
            speed = CMD_FORWARD;
            seen  = open_space(s.left);
            if (seen != gap_open) begin
              if (!gap_open) begin
                gap_start = s.now;
                gap_open  = 1'b1;
              end else begin
                // a gap that ends before it starts (time wrapped) counts as zero
                gap_len  = (s.now < gap_start) ? '0 : s.now - gap_start;
                gap_open = 1'b0;
              end
            end
            if (gap_len >= {16'd0, min_gap}) begin
              phase      = PH_EXEC;
              turn_count = '0;
              step       = STEP_TO_EDGE;
              wall_valid = 1'b0;
            end
          end
          PH_EXEC: begin
            if (step == STEP_TO_EDGE) begin
              gap_open = open_space(s.left);
              steer    = CMD_NEUTRAL;
              if (gap_open) begin
                speed = CMD_STOP;
                step  = STEP_TURN;
              end else begin
                speed = CMD_REVERSE;
              end
            end else begin
              if (turn_count < turn_ticks) begin
                steer      = CMD_RIGHT;
                speed      = CMD_REV_SLOW;
                turn_count = turn_count + 8'd1;
              end else begin
                steer = CMD_NEUTRAL;
                speed = CMD_REVERSE;
                warn  = 1'b1;
              end
              if (turn_count >= turn_ticks && s.rear <= rear_stop) begin
                steer = CMD_NEUTRAL;
                speed = CMD_STOP;
                phase = PH_DONE;
              end
            end
          end
          PH_DONE: begin
            // commands held until the light unit acks
            if (s.ack) begin
              active_f = 1'b0;
              done_f   = 1'b1;
              steer    = CMD_NEUTRAL;
              speed    = CMD_STOP;
            end
          end
          default: begin
            steer = CMD_NEUTRAL;
            speed = CMD_STOP;
          end
        endcase
      end
      c.steer        = steer;
      c.speed        = speed;
      c.updated      = upd;
      c.parking_done = done_f;
      c.active       = active_f;
      c.rear_warn    = warn;
      due_cmds.push_back(c);
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < 100) $display("ERROR: result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task match_cmd(logic [OUT_W-1:0] tdata);
      cmd_t got;
      cmd_t want;
      got = tdata[$bits(cmd_t)-1:0];
      results_seen++;
      if (due_cmds.size() == 0) begin
        flag_mismatch($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = due_cmds.pop_front();
      if (got.steer !== want.steer)
        flag_mismatch($sformatf("steer_cmd got %0d want %0d", got.steer, want.steer));
      if (got.speed !== want.speed)
        flag_mismatch($sformatf("speed_cmd got %0d want %0d", got.speed, want.speed));
      if (got.updated !== want.updated)
        flag_mismatch($sformatf("updated got %b want %b", got.updated, want.updated));
      if (got.parking_done !== want.parking_done)
        flag_mismatch($sformatf("parking_done got %b want %b",
                                got.parking_done, want.parking_done));
      if (got.active !== want.active)
        flag_mismatch($sformatf("active got %b want %b", got.active, want.active));
      if (got.rear_warn !== want.rear_warn)
        flag_mismatch($sformatf("rear_warn got %b want %b", got.rear_warn, want.rear_warn));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [SENSE_W-1:0]   in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  drive_cmd_tracker sb;

  // Stimulus knobs shared with the receiver process.
  int unsigned  idle_pct   = 0;
  int unsigned  stall_pct  = 0;
  int unsigned  noise_pct  = 0;
  bit           hold_req   = 1'b0;
  int unsigned  hold_left  = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycles     = 0;
  logic [47:0]  now_cur;

  parking_maneuver_sequencer_unit #(
    .TIME_BITS (48)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side. Handshake values are read right after the edge, i.e. what the
  // block saw at that edge; out_tready is updated by NBA for the next one.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.match_cmd(out_tdata);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req) begin
        // long hold-off: sender keeps offering, block must fill and stall in_tready
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic sense_t rand_sense();
    sense_t s;
    s.now         = rand48();
    s.left        = 16'($urandom);
    s.left_stamp  = rand48();
    s.right_stamp = rand48();
    s.rear        = 16'($urandom);
    s.rear_stamp  = rand48();
    s.ack         = 1'($urandom);
    return s;
  endfunction

  // Fresh stamp: age anywhere up to the limit, with the exact limit now and then.
  function automatic logic [47:0] fresh_stamp();
    logic [31:0] age;
    age = ($urandom_range(7) == 0) ? sb.stale_limit : $urandom_range(sb.stale_limit, 0);
    return now_cur - {16'd0, age};
  endfunction

  function automatic logic [47:0] stale_stamp();
    return now_cur - ({16'd0, sb.stale_limit} + 48'd1 + 48'($urandom_range(1000)));
  endfunction

  function automatic sense_t make_sense(logic [15:0] left, logic [15:0] rear, logic ack);
    sense_t s;
    s.now         = now_cur;
    s.left        = left;
    s.left_stamp  = fresh_stamp();
    s.right_stamp = fresh_stamp();
    s.rear        = rear;
    s.rear_stamp  = fresh_stamp();
    s.ack         = ack;
    return s;
  endfunction

  function automatic logic [15:0] rear_low();
    return 16'($urandom_range(sb.rear_stop, 0));
  endfunction

  function automatic logic [15:0] rear_high();
    return (sb.rear_stop < 16'hFFFF) ? 16'($urandom_range(65535, sb.rear_stop + 1))
                                     : 16'($urandom);
  endfunction

  // Offer one update transaction; in_tvalid stays high into the next call
  // when no idle cycle falls between them.
  task automatic send_item(logic [1:0] op, sense_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(SENSE_W - $bits(sense_t)){1'b0}}, s};
    do @(posedge clk); while (!in_tready);
    sb.take_update(op, s);
    items_sent++;
  endtask

  // Stale readings, unused opcodes, random garbage and the odd stop.
  task automatic send_noise();
    sense_t s;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      s = make_sense(16'($urandom), 16'($urandom), 1'($urandom));
      case ($urandom_range(2))
        0: s.left_stamp  = stale_stamp();
        1: s.right_stamp = stale_stamp();
        default: s.rear_stamp = stale_stamp();
      endcase
      send_item(OP_UPDATE, s);
    end else if (pick < 80) begin
      send_item(OP_IDLE, rand_sense());
    end else if (pick < 95) begin
      send_item(2'($urandom_range(3)), rand_sense());
    end else begin
      send_item(OP_STOP, rand_sense());
    end
  endtask

  task automatic upd(logic [15:0] left, logic [15:0] rear, logic ack, longint unsigned adv);
    if ($urandom_range(99) < noise_pct) send_noise();
    now_cur = now_cur + adv[47:0];
    send_item(OP_UPDATE, make_sense(left, rear, ack));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Sender pause: stop offering until every owed command has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] m, logic [31:0] g, logic [15:0] r, logic [7:0] t,
                         logic [31:0] st);
    drain();
    write_reg(REG_WALL_MARGIN, {16'd0, m});
    write_reg(REG_MIN_GAP, g);
    write_reg(REG_REAR_STOP, {16'd0, r});
    write_reg(REG_TURN_TICKS, {24'd0, t});
    write_reg(REG_STALE_LIMIT, st);
    cfg_valid <= 1'b0;
  endtask

  // One full parking run with random content: search with a timed gap,
  // reverse to the edge, turn, reverse to the rear stop, wait for the ack.
  task automatic run_episode();
    int unsigned     m;
    int unsigned     hi;
    logic [15:0]     w;
    longint unsigned target;
    longint unsigned elapsed;
    longint unsigned step_adv;
    longint unsigned extra;
    bit              short_gap;
    bit              ended;
    m = sb.wall_margin;
    if ($urandom_range(9) != 0) send_item(OP_RESTART, rand_sense());
    if (m > 65534) begin
      // no reading can ever count as open space; just churn the search phase
      repeat ($urandom_range(12, 4))
        upd(16'($urandom), 16'($urandom), 1'($urandom), $urandom_range(200, 1));
      return;
    end
    hi = 65534 - m;
    w  = 16'($urandom_range(hi, 0));

    // search: wall, open space, wall again; a short gap first now and then
    repeat (2) begin
      upd(w, 16'($urandom), 1'($urandom), $urandom_range(100, 1));
      repeat ($urandom_range(3))
        upd(16'(w + $urandom_range(m, 0)), 16'($urandom), 1'($urandom),
            $urandom_range(100, 1));
      short_gap = ($urandom_range(4) == 0) && (sb.min_gap != 0);
      if (short_gap) begin
        target = $urandom_range(sb.min_gap - 1, 0);
      end else begin
        extra  = $urandom_range((sb.min_gap > 20000) ? 5000 : sb.min_gap / 4, 0);
        target = longint'(sb.min_gap) + extra;
      end
      upd(16'($urandom_range(65535, w + m + 1)), 16'($urandom), 1'($urandom),
          $urandom_range(100, 1));
      elapsed = 0;
      repeat ($urandom_range(3)) begin
        step_adv = $urandom_range(32'(target / 4), 0);
        elapsed  = elapsed + step_adv;
        upd(16'($urandom_range(65535, w + m + 1)), 16'($urandom), 1'($urandom), step_adv);
      end
      upd(16'(w + $urandom_range(m, 0)), 16'($urandom), 1'($urandom), target - elapsed);
      if (!short_gap) break;
    end

    // reverse to the gap edge with a fresh wall minimum
    w = 16'($urandom_range(hi, 0));
    upd(w, 16'($urandom), 1'($urandom), $urandom_range(100, 1));
    repeat ($urandom_range(2))
      upd(16'(w + $urandom_range(m, 0)), 16'($urandom), 1'($urandom),
          $urandom_range(100, 1));
    upd(16'($urandom_range(65535, w + m + 1)), 16'($urandom), 1'($urandom),
        $urandom_range(100, 1));

    // turning; sometimes the rear stop is already reached on the last tick
    ended = 1'b0;
    for (int i = 1; i <= sb.turn_ticks; i++) begin
      if (i == sb.turn_ticks && $urandom_range(1) == 1) begin
        upd(16'($urandom), rear_low(), 1'($urandom), $urandom_range(100, 1));
        ended = 1'b1;
      end else begin
        upd(16'($urandom), rear_high(), 1'($urandom), $urandom_range(100, 1));
      end
    end
    if (!ended) begin
      repeat ($urandom_range(3))
        upd(16'($urandom), rear_high(), 1'($urandom), $urandom_range(100, 1));
      upd(16'($urandom), rear_low(), 1'($urandom), $urandom_range(100, 1));
    end

    // completed: hold until the ack
    repeat ($urandom_range(2)) upd(16'($urandom), 16'($urandom), 1'b0, $urandom_range(100, 1));
    upd(16'($urandom), 16'($urandom), 1'b1, $urandom_range(100, 1));
    repeat ($urandom_range(1))
      upd(16'($urandom), 16'($urandom), 1'($urandom), $urandom_range(100, 1));
  endtask

  task automatic run_phase(int unsigned goal, int unsigned idle, int unsigned stall);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < goal) run_episode();
  endtask

  task automatic random_config();
    set_all(16'($urandom_range(300)), $urandom_range(20000), 16'($urandom_range(1000)),
            8'($urandom_range(12)), $urandom_range(2000));
  endtask

  initial begin
    sense_t s;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_UPDATE;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_WALL_MARGIN;
    cfg_data   = '0;
    now_cur    = 48'h0000_1234_5678;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed run on reset registers, with a short turn so it stays brief.
    write_reg(REG_TURN_TICKS, 32'd2);
    cfg_valid <= 1'b0;
    send_item(OP_IDLE, rand_sense());
    // each stamp stale in turn by one microsecond
    s = make_sense(16'd500, 16'd500, 1'b0);
    s.left_stamp = now_cur - 48'd100001;
    send_item(OP_UPDATE, s);
    s = make_sense(16'd500, 16'd500, 1'b0);
    s.right_stamp = now_cur - 48'd100001;
    send_item(OP_UPDATE, s);
    s = make_sense(16'd500, 16'd500, 1'b0);
    s.rear_stamp = now_cur - 48'd100001;
    send_item(OP_UPDATE, s);
    send_item(OP_RESTART, rand_sense());
    // gap that straddles the time wrap: end before start counts as zero
    now_cur = 48'hFFFF_FFFF_FFF0;
    upd(16'd1000, 16'd0, 1'b0, 0);
    upd(16'd1050, 16'hFFFF, 1'b1, 1);
    upd(16'hFFFF, 16'd200, 1'b0, 4);
    upd(16'd1000, 16'd200, 1'b0, 20);
    // one microsecond short, then exactly min_gap
    upd(16'd1200, 16'd200, 1'b0, 5);
    upd(16'd1100, 16'd200, 1'b0, 299999);
    upd(16'd5000, 16'd200, 1'b0, 7);
    upd(16'd0, 16'd200, 1'b0, 300000);
    // reverse to edge: margin boundary is wall, one above is open
    upd(16'd2000, 16'd300, 1'b0, 3);
    upd(16'd2100, 16'd300, 1'b0, 3);
    upd(16'd2101, 16'd300, 1'b0, 3);
    // turn two ticks, reverse with warn, stop at exactly the rear limit
    upd(16'd0, 16'd0, 1'b0, 3);
    upd(16'd9, 16'd5000, 1'b0, 3);
    upd(16'd9, 16'd101, 1'b0, 3);
    upd(16'd9, 16'd100, 1'b0, 3);
    upd(16'd9, 16'd100, 1'b0, 3);
    send_item(OP_IDLE, rand_sense());
    upd(16'd9, 16'd100, 1'b1, 3);
    upd(16'd9, 16'd100, 1'b1, 3);
    send_item(OP_STOP, rand_sense());
    // sequence still steps while assist mode is off
    upd(16'd3000, 16'd3000, 1'b0, 3);

    // Random runs across idling mixes and register settings.
    noise_pct = NOISE_PCT;
    now_cur   = rand48();
    random_config();
    run_phase(180, 0, 0);
    random_config();
    run_phase(90, 61, 0);
    drain();
    run_phase(90, 61, 0);
    random_config();
    hold_req = 1'b1;
    run_phase(180, 0, 61);
    random_config();
    run_phase(180, 21, 21);
    // low extremes
    set_all(16'd0, 32'd0, 16'd0, 8'd0, 32'd0);
    run_phase(80, 21, 21);
    // high extremes; open space can never be seen
    set_all(16'hFFFF, 32'hFFFF_FFFF, 16'd0, 8'd0, 32'hFFFF_FFFF);
    run_phase(60, 0, 0);
    // largest gap and the longest turn
    set_all(16'd10, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    run_phase(100, 21, 21);

    drain();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/pms_pkg.sv
design/parking_maneuver_sequencer_unit.sv
bench/parking_maneuver_sequencer_unit_test.sv
